### rtl/bone_world_matrix_composer_core_assert.svh
// Assertion macros for the bone world matrix composer
`ifndef BONE_WORLD_MATRIX_COMPOSER_CORE_ASSERT_SVH
`define BONE_WORLD_MATRIX_COMPOSER_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BWMC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bwmc assertion failed");

// next-cycle implication
`define BWMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bwmc assertion failed");

`endif

### rtl/bwmc_pkg.sv
// Shared constants, types and functions of the bone world matrix composer
package bwmc_pkg;

    localparam int MAX_BONES  = 32;
    localparam int FRAC_BITS  = 12;
    localparam int SLOT_W     = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int LIM_W      = 7;
    localparam int MEM_DEPTH  = MAX_BONES * 12;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);

    localparam int QSIN_DEPTH = 1025;
    localparam int QSIN_AW    = $clog2(QSIN_DEPTH);
    localparam int QSIN_W     = FRAC_BITS + 1;
    localparam int TRIG_W     = FRAC_BITS + 2;
    localparam int Q_W        = 2 * TRIG_W;
    localparam int ROT_W      = 3 * FRAC_BITS + 4;
    localparam int T_W        = 64 - FRAC_BITS + 1;
    localparam int ACC_W      = T_W + 1;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // configuration register indexes
    localparam logic [0:0] REG_BONE_COUNT  = 1'd0;
    localparam logic [0:0] REG_SCALE_SHIFT = 1'd1;

    // trig register slots
    localparam logic [2:0] TG_A0 = 3'd0;
    localparam logic [2:0] TG_A1 = 3'd1;
    localparam logic [2:0] TG_B0 = 3'd2;
    localparam logic [2:0] TG_B1 = 3'd3;
    localparam logic [2:0] TG_C0 = 3'd4;
    localparam logic [2:0] TG_C1 = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE, ST_TRIG, ST_ROT, ST_LOC, ST_COMP, ST_DRAIN, ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        WB_NONE, WB_ROT_SETP, WB_ROT_SETN, WB_ROT_ADD,
        WB_LOC, WB_ACC_FIRST, WB_ACC_ADD, WB_ACC_LAST
    } wb_mode_t;

    typedef enum logic [1:0] {
        BS_TRIG, BS_ONE, BS_Q
    } bsrc_t;

    // write-back control that travels with a product down the pipe
    typedef struct packed {
        wb_mode_t   mode;
        logic [3:0] dst;
        logic       q_wr;
        logic [1:0] q_dst;
    } mac_ctl_t;

    typedef struct packed {
        logic [2:0] a_idx;
        bsrc_t      b_src;
        logic [2:0] b_idx;
        mac_ctl_t   ctl;
    } rot_op_t;

    // rotation program: pair products first, then the b0 triples
    function automatic rot_op_t rot_op(input logic [3:0] n);
        rot_op_t o;
        o = '0;
        case (n)
            4'd0:  o = '{TG_A0, BS_TRIG, TG_C1, '{WB_ROT_SETN, 4'd7, 1'b1, 2'd0}};
            4'd1:  o = '{TG_A1, BS_TRIG, TG_C0, '{WB_ROT_SETN, 4'd3, 1'b1, 2'd1}};
            4'd2:  o = '{TG_A1, BS_TRIG, TG_C1, '{WB_ROT_SETP, 4'd4, 1'b1, 2'd2}};
            4'd3:  o = '{TG_A0, BS_TRIG, TG_C0, '{WB_ROT_SETP, 4'd6, 1'b1, 2'd3}};
            4'd4:  o = '{TG_B1, BS_TRIG, TG_C1, '{WB_ROT_SETP, 4'd0, 1'b0, 2'd0}};
            4'd5:  o = '{TG_B1, BS_TRIG, TG_C0, '{WB_ROT_SETP, 4'd1, 1'b0, 2'd0}};
            4'd6:  o = '{TG_B0, BS_ONE,  TG_A0, '{WB_ROT_SETN, 4'd2, 1'b0, 2'd0}};
            4'd7:  o = '{TG_B1, BS_TRIG, TG_A0, '{WB_ROT_SETP, 4'd5, 1'b0, 2'd0}};
            4'd8:  o = '{TG_B1, BS_TRIG, TG_A1, '{WB_ROT_SETP, 4'd8, 1'b0, 2'd0}};
            4'd9:  o = '{TG_B0, BS_Q,    3'd0,  '{WB_ROT_ADD,  4'd3, 1'b0, 2'd0}};
            4'd10: o = '{TG_B0, BS_Q,    3'd3,  '{WB_ROT_ADD,  4'd4, 1'b0, 2'd0}};
            4'd11: o = '{TG_B0, BS_Q,    3'd2,  '{WB_ROT_ADD,  4'd6, 1'b0, 2'd0}};
            4'd12: o = '{TG_B0, BS_Q,    3'd1,  '{WB_ROT_ADD,  4'd7, 1'b0, 2'd0}};
            default: o = '0;
        endcase
        return o;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return 32'(v);
    endfunction

    // quarter-wave sine entry, Taylor series in Q30; elaboration only
    function automatic logic [QSIN_W-1:0] qsin(input int unsigned r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] tm;
        logic [63:0] res;
        x    = (64'(r) * HALF_PI_Q30 + 64'd512) >> 10;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 8; n++) begin
            tm = (term * x2) >> 30;
            case (n)
                1:       term = tm / 64'd6;
                2:       term = tm / 64'd20;
                3:       term = tm / 64'd42;
                4:       term = tm / 64'd72;
                5:       term = tm / 64'd110;
                6:       term = tm / 64'd156;
                7:       term = tm / 64'd210;
                default: term = tm / 64'd272;
            endcase
            if (n[0]) sum = sum - term;
            else      sum = sum + term;
        end
        res = (sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (res > (64'd1 << FRAC_BITS)) res = 64'd1 << FRAC_BITS;
        return QSIN_W'(res);
    endfunction

endpackage

### rtl/bwmc_sin_rom.sv
// Quarter-wave sine ROM with registered read
module bwmc_sin_rom (
    input  logic                         clk,
    input  logic [bwmc_pkg::QSIN_AW-1:0] addr,
    output logic [bwmc_pkg::QSIN_W-1:0]  data
);
    import bwmc_pkg::*;

    logic [QSIN_W-1:0] rom [QSIN_DEPTH];

    for (genvar g = 0; g < QSIN_DEPTH; g++) begin : g_rom
        assign rom[g] = qsin(g);
    end

    always_ff @(posedge clk)
    begin
        data <= rom[addr];
    end

endmodule

### rtl/bone_world_matrix_composer_core.sv
// Bone world matrix composer top level: sequencer, shared multiplier, matrix store
// Bones are taken one at a time, only while idle; after the sine ROM walk and the
//   58 products through the one 32x32 multiplier, the four rows follow, one row per
//   accepted output transfer, and the next bone is taken after the last row.
//   A skipped bone produces no rows and leaves the sequencer in idle.
// Reset clears configuration, valid marks and sequencer; the store is not cleared.
`include "bone_world_matrix_composer_core_assert.svh"

module bone_world_matrix_composer_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [5:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // bone_slot, parent_delta, scale_x, scale_y, scale_z, rot_x, rot_y, rot_z,
    // trans_x, trans_y, trans_z
    input  logic [271:0] s_tdata,
    // frame_start
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_slot, row_index, col_zero, col_one, col_two, pad bit
    output logic [103:0] m_tdata,
    output logic         m_tlast
);
    import bwmc_pkg::*;

    state_t state_reg, state_next;

    logic [5:0]           bone_count_reg;
    logic [3:0]           shift_reg;
    logic [MAX_BONES-1:0] marks_reg;
    logic [3:0]           cnt_reg;
    logic [1:0]           i_reg, j_reg, k_reg;
    logic [1:0]           row_reg;
    logic [SLOT_W-1:0]    slot_reg, par_slot_reg;
    logic                 par_ok_reg;

    logic [11:0]                ang_reg   [3];
    logic signed [31:0]         scale_reg [3];
    logic signed [TRIG_W-1:0]   trig_reg  [6];
    logic signed [Q_W-1:0]      q_reg     [4];
    logic signed [ROT_W-1:0]    rot_reg   [9];
    logic signed [31:0]         loc_reg   [12];
    logic signed [31:0]         par_reg   [12];
    logic signed [31:0]         w_reg     [12];
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [63:0]         prod_reg;
    logic signed [T_W-1:0]      t_reg;
    mac_ctl_t                   ctl1_reg, ctl2_reg, ctl_issue;

    logic                 trig_wr_reg, trig_neg_reg;
    logic [2:0]           trig_idx_reg;
    logic                 pf_on_reg, pf_cap_reg;
    logic [3:0]           pf_cnt_reg, pf_idx_reg;

    logic [31:0]          mem [MEM_DEPTH];
    logic [31:0]          mem_q_reg;

    logic signed [31:0]   out_c0_reg, out_c1_reg, out_c2_reg;

    // input decode
    logic                 acc_in, frame_start;
    logic signed [15:0]   in_slot, in_pd;
    logic [16:0]          par_sum;
    logic [LIM_W-1:0]     lim;
    logic                 slot_ok, par_ok;
    logic [MAX_BONES-1:0] marks_eff;

    assign acc_in      = s_tvalid && s_tready;
    assign frame_start = s_tuser[0];
    assign in_slot     = s_tdata[15:0];
    assign in_pd       = s_tdata[31:16];
    assign lim = (LIM_W'(bone_count_reg) > LIM_W'(MAX_BONES)) ?
                 LIM_W'(MAX_BONES) : LIM_W'(bone_count_reg);
    assign marks_eff = frame_start ? '0 : marks_reg;
    assign par_sum   = {in_slot[15], in_slot} + {in_pd[15], in_pd};
    assign slot_ok   = !in_slot[15] && (in_slot[14:0] < 15'(lim));
    assign par_ok    = !par_sum[16] && (par_sum[15:0] < 16'(lim)) &&
                       (par_sum[15:0] != 16'(in_slot)) &&
                       marks_eff[par_sum[SLOT_W-1:0]];

    // sequencer controls
    logic                 comp_done;
    logic signed [31:0]   op_a, op_b;
    logic [QSIN_AW-1:0]   rom_addr;
    logic [QSIN_W-1:0]    rom_data;
    logic                 rom_neg, trig_issue;
    logic [11:0]          ang_sel;
    logic [3:0]           e_ik, e_kj, e_ij;
    rot_op_t              rop;
    logic [1:0]           row_sel;
    logic                 load_row;

    assign comp_done = (ctl2_reg.mode == WB_ACC_LAST) && (ctl2_reg.dst == 4'd11);
    assign e_ik = 4'(i_reg) * 4'd3 + 4'(k_reg);
    assign e_kj = 4'(k_reg) * 4'd3 + 4'(j_reg);
    assign e_ij = 4'(i_reg) * 4'd3 + 4'(j_reg);
    assign rop  = rot_op(cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (acc_in && slot_ok) state_next = ST_TRIG;
            ST_TRIG:  if (cnt_reg == 4'd6) state_next = ST_ROT;
            ST_ROT:   if (cnt_reg == 4'd12) state_next = ST_LOC;
            ST_LOC:   if (i_reg == 2'd2 && k_reg == 2'd2) state_next = ST_COMP;
            ST_COMP:  if (i_reg == 2'd3 && j_reg == 2'd2 && k_reg == 2'd2)
                          state_next = ST_DRAIN;
            ST_DRAIN: if (comp_done) state_next = ST_OUT;
            ST_OUT:   if (m_tready && row_reg == 2'd3) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready   = (state_reg == ST_IDLE);
        m_tvalid   = (state_reg == ST_OUT);
        op_a       = '0;
        op_b       = '0;
        ctl_issue  = '0;
        trig_issue = 1'b0;
        ang_sel    = ang_reg[cnt_reg[2:1]];
        if (cnt_reg[0]) ang_sel = ang_sel + 12'd1024;
        rom_neg    = ang_sel[11];
        rom_addr   = ang_sel[10] ? (QSIN_AW'(1024) - QSIN_AW'(ang_sel[9:0]))
                                 : QSIN_AW'(ang_sel[9:0]);
        load_row   = 1'b0;
        row_sel    = row_reg + 2'd1;
        case (state_reg)
            ST_TRIG:
            begin
                trig_issue = (cnt_reg < 4'd6);
            end
            ST_ROT:
            begin
                op_a = 32'(trig_reg[rop.a_idx]);
                case (rop.b_src)
                    BS_TRIG: op_b = 32'(trig_reg[rop.b_idx]);
                    BS_ONE:  op_b = 32'sd1 <<< FRAC_BITS;
                    BS_Q:    op_b = 32'(q_reg[rop.b_idx[1:0]]);
                    default: op_b = '0;
                endcase
                ctl_issue = rop.ctl;
            end
            ST_LOC:
            begin
                op_a = 32'(rot_reg[e_ik] >>> (2 * FRAC_BITS));
                op_b = scale_reg[i_reg];
                ctl_issue = '{WB_LOC, e_ik, 1'b0, 2'd0};
            end
            ST_COMP:
            begin
                op_a = loc_reg[e_ik];
                op_b = par_reg[e_kj];
                ctl_issue.dst = e_ij;
                case (k_reg)
                    2'd0:    ctl_issue.mode = WB_ACC_FIRST;
                    2'd1:    ctl_issue.mode = WB_ACC_ADD;
                    default: ctl_issue.mode = WB_ACC_LAST;
                endcase
            end
            ST_DRAIN:
            begin
                load_row = comp_done;
                row_sel  = 2'd0;
            end
            ST_OUT:
            begin
                load_row = m_tready && (row_reg != 2'd3);
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    bwmc_sin_rom u_sin_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bone_count_reg <= '0;
            shift_reg      <= '0;
            marks_reg      <= '0;
            cnt_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            row_reg        <= '0;
            ctl1_reg       <= '0;
            ctl2_reg       <= '0;
            trig_wr_reg    <= 1'b0;
            pf_on_reg      <= 1'b0;
            pf_cap_reg     <= 1'b0;
            pf_cnt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_BONE_COUNT:  bone_count_reg <= cfg_wdata;
                    REG_SCALE_SHIFT: shift_reg      <= cfg_wdata[3:0];
                    default:         bone_count_reg <= bone_count_reg;
                endcase
            end
            if (acc_in && frame_start) marks_reg <= '0;
            if (state_reg == ST_DRAIN && comp_done) marks_reg[slot_reg] <= 1'b1;

            if (state_next != state_reg)
            begin
                cnt_reg <= '0;
                i_reg   <= '0;
                j_reg   <= '0;
                k_reg   <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (state_reg == ST_LOC || state_reg == ST_COMP)
                begin
                    if (k_reg == 2'd2)
                    begin
                        k_reg <= '0;
                        if (state_reg == ST_LOC || j_reg == 2'd2)
                        begin
                            j_reg <= '0;
                            i_reg <= i_reg + 2'd1;
                        end
                        else
                        begin
                            j_reg <= j_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
            end

            if (load_row) row_reg <= row_sel;

            ctl1_reg    <= ctl_issue;
            ctl2_reg    <= ctl1_reg;
            trig_wr_reg <= trig_issue;

            pf_cap_reg <= pf_on_reg;
            if (acc_in && slot_ok)
            begin
                pf_on_reg  <= 1'b1;
                pf_cnt_reg <= '0;
            end
            else if (pf_on_reg)
            begin
                pf_cnt_reg <= pf_cnt_reg + 4'd1;
                if (pf_cnt_reg == 4'd11) pf_on_reg <= 1'b0;
            end
        end
    end

    // datapath
    logic signed [63:0]       prod_c;
    logic signed [ACC_W-1:0]  acc_sum, acc_base;
    logic signed [TRIG_W-1:0] rom_val;
    logic                     mem_we;
    logic [MEM_AW-1:0]        mem_waddr, mem_raddr;
    logic signed [31:0]       w_final;

    assign prod_c    = 64'(op_a) * 64'(op_b);
    assign acc_sum   = acc_reg + ACC_W'(t_reg);
    assign acc_base  = (ctl2_reg.dst >= 4'd9) ? ACC_W'(par_reg[ctl2_reg.dst]) : '0;
    assign rom_val   = TRIG_W'({1'b0, rom_data});
    assign w_final   = sat32(64'(acc_sum));
    assign mem_we    = (ctl2_reg.mode == WB_ACC_LAST);
    assign mem_waddr = MEM_AW'(slot_reg) * MEM_AW'(12) + MEM_AW'(ctl2_reg.dst);
    assign mem_raddr = MEM_AW'(par_slot_reg) * MEM_AW'(12) + MEM_AW'(pf_cnt_reg);

    function automatic logic signed [31:0] out_val(input logic signed [31:0] v,
                                                   input logic [1:0] row,
                                                   input logic [3:0] sh);
        if (row == 2'd3) return v;
        return sat32(64'(v) <<< sh);
    endfunction

    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            slot_reg     <= SLOT_W'(in_slot);
            par_slot_reg <= par_sum[SLOT_W-1:0];
            par_ok_reg   <= par_ok;
            scale_reg[0] <= s_tdata[63:32];
            scale_reg[1] <= s_tdata[95:64];
            scale_reg[2] <= s_tdata[127:96];
            ang_reg[0]   <= s_tdata[139:128];
            ang_reg[1]   <= s_tdata[155:144];
            ang_reg[2]   <= s_tdata[171:160];
            loc_reg[9]   <= s_tdata[207:176];
            loc_reg[10]  <= s_tdata[239:208];
            loc_reg[11]  <= s_tdata[271:240];
        end

        trig_neg_reg <= rom_neg;
        trig_idx_reg <= cnt_reg[2:0];
        if (trig_wr_reg) trig_reg[trig_idx_reg] <= trig_neg_reg ? -rom_val : rom_val;

        pf_idx_reg <= pf_cnt_reg;
        if (pf_cap_reg)
        begin
            if (par_ok_reg)
                par_reg[pf_idx_reg] <= mem_q_reg;
            else if (pf_idx_reg == 4'd0 || pf_idx_reg == 4'd4 || pf_idx_reg == 4'd8)
                par_reg[pf_idx_reg] <= 32'sd1 <<< FRAC_BITS;
            else
                par_reg[pf_idx_reg] <= '0;
        end

        // stage 1: product, stage 2: rounding, stage 3: write-back
        prod_reg <= prod_c;
        if (ctl1_reg.mode == WB_LOC || ctl1_reg.mode == WB_ACC_FIRST ||
            ctl1_reg.mode == WB_ACC_ADD || ctl1_reg.mode == WB_ACC_LAST)
            t_reg <= T_W'((prod_reg + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        else
            t_reg <= T_W'(prod_reg);

        case (ctl2_reg.mode)
            WB_ROT_SETP:  rot_reg[ctl2_reg.dst] <= (ROT_W'(t_reg) <<< FRAC_BITS) +
                                                   (ROT_W'(1) <<< (2 * FRAC_BITS - 1));
            WB_ROT_SETN:  rot_reg[ctl2_reg.dst] <= (ROT_W'(1) <<< (2 * FRAC_BITS - 1)) -
                                                   (ROT_W'(t_reg) <<< FRAC_BITS);
            WB_ROT_ADD:   rot_reg[ctl2_reg.dst] <= rot_reg[ctl2_reg.dst] + ROT_W'(t_reg);
            WB_LOC:       loc_reg[ctl2_reg.dst] <= sat32(64'(t_reg));
            WB_ACC_FIRST: acc_reg <= acc_base + ACC_W'(t_reg);
            WB_ACC_ADD:   acc_reg <= acc_sum;
            WB_ACC_LAST:  w_reg[ctl2_reg.dst] <= w_final;
            default:      acc_reg <= acc_reg;
        endcase
        if (ctl2_reg.q_wr) q_reg[ctl2_reg.q_dst] <= Q_W'(t_reg);

        if (mem_we) mem[mem_waddr] <= w_final;
        mem_q_reg <= mem[mem_raddr];

        if (load_row)
        begin
            out_c0_reg <= out_val(w_reg[4'(row_sel) * 4'd3],         row_sel, shift_reg);
            out_c1_reg <= out_val(w_reg[4'(row_sel) * 4'd3 + 4'd1], row_sel, shift_reg);
            out_c2_reg <= out_val(w_reg[4'(row_sel) * 4'd3 + 4'd2], row_sel, shift_reg);
        end
    end

    assign m_tdata = {1'b0, out_c2_reg, out_c1_reg, out_c0_reg, row_reg, 5'(slot_reg)};
    assign m_tlast = (row_reg == 2'd3);

    `BWMC_ASSERT_IMPLY(a_out_excl, m_tvalid, !s_tready)
    `BWMC_ASSERT_IMPLY(a_store_range, mem_we, LIM_W'(slot_reg) < lim)
    `BWMC_ASSERT_NEXT(a_frame_clear, acc_in && frame_start && !slot_ok, marks_reg == '0)
    `BWMC_ASSERT_NEXT(a_mark_set, state_reg == ST_DRAIN && comp_done, marks_reg[slot_reg])

endmodule

### sim/tb_bone_world_matrix_composer_core.sv
// Self-checking testbench for the bone world matrix composer core
`timescale 1ns/1ps

module tb_bone_world_matrix_composer_core;
    import bwmc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE_Q      = 1 << FRAC_BITS;
    localparam int SETTLE     = 100;
    localparam int STALL_LIM  = 5000;

    typedef struct {
        bit                 fs;
        logic signed [15:0] slot;
        logic signed [15:0] pdelta;
        logic signed [31:0] sx, sy, sz;
        logic signed [15:0] rx, ry, rz;
        logic signed [31:0] tx, ty, tz;
    } bone_t;

    typedef struct {
        logic [4:0]         slot;
        logic [1:0]         row;
        logic signed [31:0] c0, c1, c2;
        logic               last;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [0:0]   cfg_addr;
    logic [5:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [271:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tlast;

    bone_world_matrix_composer_core uut (.*);

    // predictor state
    longint             sine_q [0:1024];
    logic signed [31:0] world_rows [MAX_BONES][12];
    bit [MAX_BONES-1:0] parent_ok;
    int                 slots_in_use;
    int                 axis_shift;
    row_t               rows_due [$];

    int  mismatches;
    bit  quiet;
    int  ready_hold;
    int  idle_cycles;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint rnd_shift(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint quarter_wave(int r);
        longint unsigned x, x2, term, acc, res;
        x    = (longint'(r) * HALF_PI_Q30 + 512) >> 10;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc = acc - term;
            else            acc = acc + term;
        end
        res = (acc + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (res > ONE_Q) res = ONE_Q;
        return longint'(res);
    endfunction

    function automatic longint sine_of(int a);
        int q, r;
        a = a & 4095;
        q = a >> 10;
        r = a & 1023;
        case (q)
            0:       return sine_q[r];
            1:       return sine_q[1024 - r];
            2:       return -sine_q[r];
            default: return -sine_q[1024 - r];
        endcase
    endfunction

    function automatic longint cosine_of(int a);
        return sine_of((a & 4095) + 1024);
    endfunction

    // world = local * parent, rows pushed in output order
    function automatic void compose_bone(bone_t b);
        longint one, lim, idx, par, a0, a1, b0, b1, c0, c1, acc, v;
        longint rot [9];
        longint loc [12];
        longint pm [12];
        longint w [12];
        longint sc [3];
        row_t   r;
        one = ONE_Q;
        if (b.fs) parent_ok = '0;
        lim = (slots_in_use < MAX_BONES) ? slots_in_use : MAX_BONES;
        idx = b.slot;
        if (idx < 0 || idx >= lim) return;
        par = idx + longint'(b.pdelta);
        a0 = sine_of(b.rx); a1 = cosine_of(b.rx);
        b0 = sine_of(b.ry); b1 = cosine_of(b.ry);
        c0 = sine_of(b.rz); c1 = cosine_of(b.rz);
        rot[0] = b1 * c1 * one;
        rot[1] = b1 * c0 * one;
        rot[2] = -b0 * one * one;
        rot[3] = b0 * a0 * c1 - a1 * c0 * one;
        rot[4] = a1 * c1 * one + b0 * a0 * c0;
        rot[5] = b1 * a0 * one;
        rot[6] = a0 * c0 * one + b0 * a1 * c1;
        rot[7] = b0 * a1 * c0 - a0 * c1 * one;
        rot[8] = b1 * a1 * one;
        sc[0] = b.sx; sc[1] = b.sy; sc[2] = b.sz;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                loc[i*3+j] = clip32(rnd_shift(rnd_shift(rot[i*3+j], 2*FRAC_BITS) * sc[i],
                                              FRAC_BITS));
        loc[9] = b.tx; loc[10] = b.ty; loc[11] = b.tz;
        if (par >= 0 && par < lim && par != idx && parent_ok[par]) begin
            for (int k = 0; k < 12; k++) pm[k] = world_rows[par][k];
        end
        else begin
            for (int k = 0; k < 12; k++) pm[k] = 0;
            pm[0] = one; pm[4] = one; pm[8] = one;
        end
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = (i == 3) ? pm[9+j] : 0;
                for (int k = 0; k < 3; k++)
                    acc += rnd_shift(loc[i*3+k] * pm[k*3+j], FRAC_BITS);
                w[i*3+j] = clip32(acc);
            end
        for (int k = 0; k < 12; k++) world_rows[idx][k] = w[k];
        parent_ok[idx] = 1'b1;
        for (int i = 0; i < 4; i++) begin
            longint cv [3];
            for (int j = 0; j < 3; j++) begin
                v = w[i*3+j];
                if (i < 3) v = clip32(v * (longint'(1) <<< axis_shift));
                cv[j] = v;
            end
            r.slot = idx[4:0];
            r.row  = i[1:0];
            r.c0   = cv[0][31:0];
            r.c1   = cv[1][31:0];
            r.c2   = cv[2][31:0];
            r.last = (i == 3);
            rows_due.push_back(r);
        end
    endfunction

    function automatic bone_t mk(bit fs, int slot, int pd, int sx, int sy, int sz,
                                 int rx, int ry, int rz, int tx, int ty, int tz);
        bone_t b;
        b.fs = fs; b.slot = slot; b.pdelta = pd;
        b.sx = sx; b.sy = sy; b.sz = sz;
        b.rx = rx; b.ry = ry; b.rz = rz;
        b.tx = tx; b.ty = ty; b.tz = tz;
        return b;
    endfunction

    task automatic send_bone(bone_t b);
        int gap;
        gap = quiet ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {b.tz, b.ty, b.tx, b.rz, b.ry, b.rx, b.sz, b.sy, b.sx, b.pdelta, b.slot};
        s_tuser  <= b.fs;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        compose_bone(b);
    endtask

    task automatic drain_rows();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (rows_due.size() != 0) @(posedge clk);
        // skipped bones produce no rows and do not take the sequencer out of idle
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[5:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_BONE_COUNT) slots_in_use = val & 63;
        else                       axis_shift   = val & 15;
    endtask

    task automatic set_mode(int count, int shift);
        drain_rows();
        write_reg(REG_BONE_COUNT, count);
        write_reg(REG_SCALE_SHIFT, shift);
    endtask

    function automatic int rand_scale();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom_range(0, 255) - 128;
            default: return $urandom_range(0, 16384) - 8192;
        endcase
    endfunction

    function automatic bone_t rand_bone(bit fs, int slot, int pd);
        return mk(fs, slot, pd, rand_scale(), rand_scale(), rand_scale(),
                  $urandom(), $urandom(), $urandom(),
                  ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 20) - (1 << 19),
                  ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 20) - (1 << 19),
                  ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 20) - (1 << 19));
    endfunction

    task automatic test_directed();
        int mx, mn;
        mx = 32'h7FFFFFFF;
        mn = 32'h80000000;
        set_mode(32, 0);
        send_bone(mk(1, 0, 0, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 0, 0, 0));
        send_bone(mk(0, 1, -1, ONE_Q, ONE_Q, ONE_Q, 1024, 0, 0, 4096, -4096, 100));
        send_bone(mk(0, 2, -1, 2*ONE_Q, ONE_Q/2, -ONE_Q, 0, 1024, 0, 1, 2, 3));
        send_bone(mk(0, 3, -1, ONE_Q, ONE_Q, ONE_Q, 0, 0, 2048, 0, 0, 0));
        send_bone(mk(0, 4, -4, mx, mn, mx, 3072, 2048, 1024, mx, mn, mx));
        send_bone(mk(0, 5, -1, mx, mx, mn, -32768, 32767, -1, mn, mx, mn));
        send_bone(mk(0, 6, -2, mn, mn, mn, 512, -512, 4095, mx, mx, mx));
        send_bone(mk(0, 31, 0, ONE_Q, ONE_Q, ONE_Q, 100, 200, 300, 7, 8, 9));
        send_bone(mk(0, 7, 32767, ONE_Q, ONE_Q, ONE_Q, 10, 20, 30, 0, 0, 0));
        send_bone(mk(0, 8, -32768, ONE_Q, ONE_Q, ONE_Q, 10, 20, 30, 0, 0, 0));
        send_bone(mk(0, 9, 22, ONE_Q, ONE_Q, ONE_Q, 10, 20, 30, 0, 0, 0));
        send_bone(mk(0, 10, 20, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 5, 5, 5));
        send_bone(mk(0, -1, 1, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 0, 0, 0));
        send_bone(mk(0, 32, -1, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 0, 0, 0));
        send_bone(mk(0, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_bone(mk(0, 32767, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // stale parent from the previous bones still counts
        send_bone(mk(0, 11, -10, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 1, 1, 1));
        // frame start on a skipped bone still clears the marks
        send_bone(mk(1, 40, 0, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 0, 0, 0));
        send_bone(mk(0, 12, -11, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 1, 1, 1));
        send_bone(mk(1, 13, -1, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 1, 1, 1));
        set_mode(32, 15);
        send_bone(mk(1, 0, 0, mx, 3, -ONE_Q, 333, 777, 1500, mx, mn, 0));
        send_bone(mk(0, 1, -1, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 0, 0, 0));
        set_mode(63, 1);
        send_bone(mk(1, 31, -31, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 0, 0, 0));
        send_bone(mk(0, 32, -1, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 0, 0, 0));
    endtask

    // mostly well-formed frames of chained bones, some noise on top
    task automatic test_random(int count, int shift, int items);
        int n, slot, top;
        set_mode(count, shift);
        n = 0;
        while (n < items) begin
            if ($urandom_range(0, 4) == 0) begin
                send_bone(rand_bone($urandom_range(0, 1), $urandom(), $urandom()));
                n++;
            end
            else begin
                top = $urandom_range(1, 40);
                for (slot = 0; slot < top && n < items; slot++) begin
                    send_bone(rand_bone(slot == 0, slot,
                                        (slot == 0 || $urandom_range(0, 7) == 0) ? 0 :
                                        -$urandom_range(1, slot)));
                    n++;
                end
            end
        end
    endtask

    always @(negedge clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end
        else if (!quiet && rst_n && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 15);
        end
        else begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 20);
        end
    end

    always @(posedge clk) begin
        row_t e;
        if (m_tvalid && m_tready) begin
            if (rows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected row transfer: %h", m_tdata);
            end
            else begin
                e = rows_due.pop_front();
                if (m_tdata[4:0] !== e.slot || m_tdata[6:5] !== e.row ||
                    m_tdata[38:7] !== e.c0 || m_tdata[70:39] !== e.c1 ||
                    m_tdata[102:71] !== e.c2 || m_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row mismatch: exp slot %0d row %0d %0d %0d %0d last %0b, got slot %0d row %0d %0d %0d %0d last %0b",
                                 e.slot, e.row, e.c0, e.c1, e.c2, e.last,
                                 m_tdata[4:0], m_tdata[6:5], $signed(m_tdata[38:7]),
                                 $signed(m_tdata[70:39]), $signed(m_tdata[102:71]), m_tlast);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIM) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        for (int r = 0; r <= 1024; r++) sine_q[r] = quarter_wave(r);
        parent_ok    = '0;
        slots_in_use = 0;
        axis_shift   = 0;
        mismatches   = 0;
        quiet        = 1'b0;
        ready_hold   = 0;
        idle_cycles  = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(32, 0, 90);
        test_random(5, 3, 60);
        test_random(63, 15, 80);
        test_random(0, 7, 20);
        test_random(1, 1, 40);
        test_random(20, 12, 80);
        quiet = 1'b1;
        test_random(32, 2, 90);
        drain_rows();

        if (mismatches == 0 && rows_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
